>>> design/ttb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared constants of the trie transition table builder.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int unsigned NUM_SYMBOLS = 512;
  localparam int unsigned MAX_STATES  = 1024;
  localparam int unsigned MAX_SEQS    = 256;

  // Field widths of the stream items.
  localparam int unsigned SYM_W   = 9;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned STATE_W = 10;

  // Counter widths: wide enough to hold the limit itself.
  localparam int unsigned FREE_W = $clog2(MAX_STATES) + 1;
  localparam int unsigned ECNT_W = $clog2(MAX_SEQS) + 1;

  // Transition table memory: one entry per (state, symbol).
  localparam int unsigned SYM_AW = $clog2(NUM_SYMBOLS);
  localparam int unsigned TT_AW  = STATE_W + SYM_AW;

  // End table memory: {state, sig_id} per recorded sequence.
  localparam int unsigned ET_AW = (MAX_SEQS > 1) ? $clog2(MAX_SEQS) : 1;
  localparam int unsigned ET_DW = STATE_W + ID_W;

  localparam logic [STATE_W-1:0] ROOT_STATE = STATE_W'(1);
  localparam logic [FREE_W-1:0]  FIRST_FREE = FREE_W'(2);

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned IN_TDATA_W  = ((SYM_W + ID_W + 7) / 8) * 8;
  localparam int unsigned OUT_FLD_W   = STATE_W + 4;
  localparam int unsigned OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  typedef struct packed {
    logic                end_full;
    logic                end_recorded;
    logic                table_full;
    logic                created;
    logic [STATE_W-1:0]  state;
  } result_t;

endpackage

>>> design/ttb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module ttb_ram #(
  parameter int unsigned DW = 10,
  parameter int unsigned AW = 19
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  // Read data holds its value between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/trie_transition_table_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_transition_table_builder
// Builds a trie automaton from symbol sequences held in one transition memory.
// ----------------------------------------------------------------------------
//  Port group  Dir  Fields (low bit first)
//  s_axis      in   tdata: symbol[8:0], sig_id[16:9]; tlast: last of sequence
//  m_axis      out  tdata: state[9:0], created, table_full, end_recorded,
//                   end_full
//
//  An item passes through the idle and lookup states: the accept issues the
//  table read; in the lookup state the read data is taken, the decision made,
//  the new edge written back and the result register loaded.
//  After reset a clearing pass zeroes the transition memory, one entry a
//  cycle, with tready low. A waiting result does not block acceptance; a
//  held result stalls the next item in its lookup cycle.
// ----------------------------------------------------------------------------
module trie_transition_table_builder
  import ttb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // symbol, sig_id
  input  logic                   s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o    // state, created, table_full,
                                                   // end_recorded, end_full
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]         st_q, st_d;
  logic [TT_AW-1:0]   clr_q, clr_d;
  logic [STATE_W-1:0] cur_q, cur_d;
  logic [FREE_W-1:0]  free_q, free_d;
  logic [ECNT_W-1:0]  ecnt_q, ecnt_d;
  logic [SYM_W-1:0]   sym_q;
  logic [ID_W-1:0]    id_q;
  logic               last_q;
  logic               mvalid_q, mvalid_d;
  result_t            res_q, res_d;

  logic               accept, finish;
  logic [SYM_W-1:0]   in_sym;
  logic [ID_W-1:0]    in_id;

  logic               tt_we, tt_re;
  logic [TT_AW-1:0]   tt_addr;
  logic [STATE_W-1:0] tt_wdata, tt_rdata;

  logic               sym_ok, hit, miss, alloc_ok, end_ok;
  logic [STATE_W-1:0] reached;

  logic [ET_DW-1:0]   end_mem_q [MAX_SEQS];

  assign in_sym = s_axis_tdata_i[SYM_W-1:0];
  assign in_id  = s_axis_tdata_i[SYM_W+ID_W-1:SYM_W];

  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign finish          = (st_q == ST_LOOK) && (!mvalid_q || m_axis_tready_i);

  // Edge lookup for the item in the lookup stage.
  always_comb begin
    sym_ok   = ({1'b0, sym_q} < (SYM_W + 1)'(NUM_SYMBOLS)) &&
               ({1'b0, cur_q} < (STATE_W + 1)'(MAX_STATES));
    hit      = sym_ok && (tt_rdata != '0);
    miss     = sym_ok && (tt_rdata == '0);
    alloc_ok = (free_q < FREE_W'(MAX_STATES));
    end_ok   = (ecnt_q < ECNT_W'(MAX_SEQS));
    if (hit) begin
      reached = tt_rdata;
    end else if (miss && alloc_ok) begin
      reached = free_q[STATE_W-1:0];
    end else begin
      reached = cur_q;
    end
    res_d.state        = reached;
    res_d.created      = miss && alloc_ok;
    res_d.table_full   = miss && !alloc_ok;
    res_d.end_recorded = last_q && end_ok;
    res_d.end_full     = last_q && !end_ok;
  end

  // Memory port: clearing sweep, lookup read at accept, write-back on finish.
  always_comb begin
    tt_re    = 1'b0;
    tt_we    = 1'b0;
    tt_wdata = '0;
    tt_addr  = {cur_q, SYM_AW'(sym_q)};
    case (st_q)
      ST_CLEAR: begin
        tt_we   = 1'b1;
        tt_addr = clr_q;
      end
      ST_IDLE: begin
        tt_re   = accept;
        tt_addr = {cur_q, SYM_AW'(in_sym)};
      end
      ST_LOOK: begin
        tt_we    = finish && res_d.created;
        tt_wdata = free_q[STATE_W-1:0];
      end
      default: begin
        tt_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_d     = st_q;
    clr_d    = clr_q;
    cur_d    = cur_q;
    free_d   = free_q;
    ecnt_d   = ecnt_q;
    mvalid_d = mvalid_q && !m_axis_tready_i;
    case (st_q)
      ST_CLEAR: begin
        clr_d = clr_q + TT_AW'(1);
        if (clr_q == '1) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          st_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (finish) begin
          st_d     = ST_IDLE;
          mvalid_d = 1'b1;
          cur_d    = last_q ? ROOT_STATE : reached;
          if (res_d.created) begin
            free_d = free_q + FREE_W'(1);
          end
          if (res_d.end_recorded) begin
            ecnt_d = ecnt_q + ECNT_W'(1);
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_CLEAR;
      clr_q    <= '0;
      cur_q    <= ROOT_STATE;
      free_q   <= FIRST_FREE;
      ecnt_q   <= '0;
      mvalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      clr_q    <= clr_d;
      cur_q    <= cur_d;
      free_q   <= free_d;
      ecnt_q   <= ecnt_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sym_q  <= in_sym;
      id_q   <= in_id;
      last_q <= s_axis_tlast_i;
    end
    if (finish) begin
      res_q <= res_d;
    end
  end

  // End entries are logged in order of completion.
  always_ff @(posedge clk_i) begin
    if (finish && res_d.end_recorded) begin
      end_mem_q[ecnt_q[ET_AW-1:0]] <= {reached, id_q};
    end
  end

  ttb_ram #(
    .DW (STATE_W),
    .AW (TT_AW)
  ) u_trans_ram (
    .clk_i   (clk_i),
    .we_i    (tt_we),
    .re_i    (tt_re),
    .addr_i  (tt_addr),
    .wdata_i (tt_wdata),
    .rdata_o (tt_rdata)
  );

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - OUT_FLD_W)'(0), res_q};

endmodule

>>> design/ttb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttb_checker
// Port-level checks for the trie transition table builder.
// ----------------------------------------------------------------------------
module ttb_checker
  import ttb_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                   s_axis_tlast_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  result_t res;
  assign res = m_axis_tdata_o[OUT_FLD_W-1:0];

  // A result that is not taken stays as it is.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Each item needs its lookup cycle before the next one is taken.
  a_two_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("item accepted during lookup");

  a_alloc_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(res.created && res.table_full))
    else $error("created and table_full both set");

  a_end_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(res.end_recorded && res.end_full))
    else $error("end_recorded and end_full both set");

  // Newly allocated states never reuse the two states present from reset.
  a_new_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.created |-> res.state >= FIRST_FREE[STATE_W-1:0])
    else $error("allocated state below first free state");

endmodule

bind trie_transition_table_builder ttb_checker u_ttb_checker (.*);
